>>> sv/mlfst_pkg.sv
package mlfst_pkg;

	// Fraction bits of the emitted Fst and Fis words.
	localparam logic [5:0] OUT_FRAC = 6'd24;

	typedef logic signed [63:0] s64_t;
	typedef logic [63:0] u64_t;

	localparam s64_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;

	// Request to the serial multiplier: b is scanned for len bits, LSB first.
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic [6:0]  len;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	// Request to the serial divider: bits msb..0 of num, then sh zero bits.
	typedef struct packed {
		logic         start;
		logic [127:0] num;
		logic [6:0]   msb;
		logic [5:0]   sh;
		logic [63:0]  den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [63:0] quo;
	} div_rsp_t;

	function automatic s64_t sat_add(s64_t a, s64_t b);
		s64_t r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic s64_t sat_sub(s64_t a, s64_t b);
		s64_t r;
		r = a - b;
		if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic u64_t mag(s64_t x);
		return x[63] ? u64_t'(-x) : u64_t'(x);
	endfunction

	function automatic s64_t apply_sign(u64_t m, logic neg);
		return neg ? s64_t'(-m) : s64_t'(m);
	endfunction

	// Quotient limited to the largest positive 64-bit value.
	function automatic u64_t clamp_mag(u64_t q, logic ovf);
		return (ovf || q[63]) ? u64_t'(S64_MAX) : q;
	endfunction

	function automatic logic signed [31:0] clamp32(s64_t x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (x < -64'sd2147483648) r = 32'sh8000_0000;
		else r = x[31:0];
		return r;
	endfunction

endpackage

>>> sv/mlfst_div.sv
module mlfst_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mlfst_pkg::div_req_t req,
	output mlfst_pkg::div_rsp_t rsp
);
	import mlfst_pkg::*;

	logic [127:0] num_q;
	logic [6:0]   pos_q;
	logic [5:0]   sh_q;
	logic [7:0]   cnt_q;
	logic [63:0]  den_q;
	logic [63:0]  rem_q;
	logic [63:0]  quo_q;
	logic         ovf_q;
	logic         done_q;

	logic         num_phase;
	logic         in_bit;
	logic [64:0]  trial;
	logic [64:0]  diff;
	logic         ge;

	// One restoring step: bring down the next dividend bit and try the subtract.
	always_comb begin
		num_phase = cnt_q > {2'b00, sh_q};
		in_bit = num_phase ? num_q[pos_q] : 1'b0;
		trial = {rem_q, in_bit};
		diff = trial - {1'b0, den_q};
		ge = trial >= {1'b0, den_q};
	end

	// Iteration counter and done flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q <= 8'(req.msb) + 8'd1 + 8'(req.sh);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 8'd1;
			done_q <= (cnt_q == 8'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			pos_q <= req.msb;
			sh_q <= req.sh;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			quo_q <= {quo_q[62:0], ge};
			// A one shifted past bit 63 means the quotient does not fit.
			ovf_q <= ovf_q | quo_q[63];
			if (num_phase && pos_q != '0) pos_q <= pos_q - 7'd1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf = ovf_q;
	assign rsp.quo = quo_q;

endmodule

>>> sv/mlfst_mul.sv
module mlfst_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  mlfst_pkg::mul_req_t req,
	output mlfst_pkg::mul_rsp_t rsp
);
	import mlfst_pkg::*;

	logic [127:0] a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [6:0]   cnt_q;
	logic         done_q;

	// Counter for the multiplier bits still to scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q <= req.len;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
			done_q <= (cnt_q == 7'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift and add, one multiplier bit per cycle.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= {64'd0, req.a};
			b_q <= req.b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[126:0], 1'b0};
			b_q <= {1'b0, b_q[63:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

>>> sv/multilocus_fst_fis_accumulator.sv
// Channel | Direction | Handshake           | Payload
// in      | receive   | in_valid, in_stall  | eight counts, locus_passes, last_locus
// out     | send      | out_valid, out_stall| fst, fis, effective size, three flags
// cfg     | receive   | cfg_we              | cfg_wdata (generations between samples)
//
// A passing locus runs seven divisions on the one-bit-per-cycle divider (64+ACC_FRAC_BITS
// steps for four, 64 for two and 128+ACC_FRAC_BITS for the first MSP step) and ten
// products on the one-bit-per-cycle multiplier, with a hand-off around every unit operation.
// A failing or degenerate locus only passes the check state; a last locus adds the Fst and
// Fis divisions and, for a valid Fst, the effective-size product and division.
// Reset clears the sums and flags at once and sets the generation count to one.
// The input is stalled while a locus is in work; a result waits in its own register
// while the next loci are taken, and only a new last locus waits for it to drain.
module multilocus_fst_fis_accumulator #(
	parameter int COUNT_BITS = 16,
	parameter int ACC_FRAC_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COUNT_BITS-1:0] hom_one_first,
	input  logic [COUNT_BITS-1:0] het_first,
	input  logic [COUNT_BITS-1:0] hom_two_first,
	input  logic [COUNT_BITS-1:0] size_first,
	input  logic [COUNT_BITS-1:0] hom_one_second,
	input  logic [COUNT_BITS-1:0] het_second,
	input  logic [COUNT_BITS-1:0] hom_two_second,
	input  logic [COUNT_BITS-1:0] size_second,
	input  logic                  locus_passes,
	input  logic                  last_locus,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    fst_estimate,
	output logic signed [31:0]    fis_estimate,
	output logic signed [31:0]    effective_size,
	output logic                  fst_invalid,
	output logic                  fis_invalid,
	output logic                  skipped_seen,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata
);
	import mlfst_pkg::*;

	localparam s64_t       ONE = s64_t'(64'd1 << ACC_FRAC_BITS);
	localparam logic [6:0] LEN_CNT = 7'(COUNT_BITS);
	localparam logic [6:0] LEN_SMALL = 7'(COUNT_BITS + 2);
	localparam logic [6:0] LEN_D = 7'(2 * COUNT_BITS + 3);
	localparam logic [6:0] LEN_FULL = 7'd64;
	localparam logic [6:0] LEN_TAU = 7'd16;
	localparam logic [6:0] MSB_64 = 7'd63;
	localparam logic [6:0] MSB_128 = 7'd127;
	localparam logic [5:0] SH_F = 6'(ACC_FRAC_BITS);
	localparam logic [5:0] SH_NONE = 6'd0;

	typedef enum logic [25:0] {
		ST_IDLE  = 26'h0000001,
		ST_CHECK = 26'h0000002,
		ST_MA0   = 26'h0000004,
		ST_MC0   = 26'h0000008,
		ST_DT0   = 26'h0000010,
		ST_MA1   = 26'h0000020,
		ST_MC1   = 26'h0000040,
		ST_DT1   = 26'h0000080,
		ST_DMSI  = 26'h0000100,
		ST_DMSG  = 26'h0000200,
		ST_MD1   = 26'h0000400,
		ST_MD2   = 26'h0000800,
		ST_MNN   = 26'h0001000,
		ST_MDD   = 26'h0002000,
		ST_DMSP1 = 26'h0004000,
		ST_DMSP2 = 26'h0008000,
		ST_DNC   = 26'h0010000,
		ST_MFX1  = 26'h0020000,
		ST_MFX2  = 26'h0040000,
		ST_ACC1  = 26'h0080000,
		ST_ACC2  = 26'h0100000,
		ST_DFST  = 26'h0200000,
		ST_DFIS  = 26'h0400000,
		ST_MNE   = 26'h0800000,
		ST_DNE   = 26'h1000000,
		ST_DONE  = 26'h2000000
	} state_t;

	state_t state_q;
	logic   launched_q;

	logic [COUNT_BITS-1:0] h1a_q, hta_q, h2a_q, n0_q, h1b_q, htb_q, h2b_q, n1_q;
	logic                  passes_q, last_q;
	logic [15:0]           tau_q;

	s64_t sfn_q, sfd_q, sin_q, sid_q;
	logic deg_q;

	s64_t sq_q, ssi_q, msi_q, msg_q, p_q, d_q, nn_q, msp_q, nc_q, fx1_q, fx2_q, tmp_q;
	logic signed [31:0] fst_q, fis_q, ne_q;
	logic               fst_bad_q, fis_bad_q;

	logic signed [31:0] fst_out_q, fis_out_q, ne_out_q;
	logic               fst_inv_q, fis_inv_q, skip_q, out_valid_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	s64_t n0, n1, nt, c0, c1, a0, a1, base0, base1, sg, ncm1, ne_x, fst2;
	logic [127:0] fx_shift;
	u64_t fx_mag, quo_sat;
	logic unit_done;
	logic degenerate;

	mlfst_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.rsp(mul_rsp)
	);

	mlfst_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// Narrow terms of the held counts, and views of the working values and unit results.
	always_comb begin
		n0 = s64_t'(64'(n0_q));
		n1 = s64_t'(64'(n1_q));
		nt = n0 + n1;
		c0 = (s64_t'(64'(h1a_q)) <<< 1) + s64_t'(64'(hta_q));
		c1 = (s64_t'(64'(h1b_q)) <<< 1) + s64_t'(64'(htb_q));
		a0 = (n0 <<< 1) - c0;
		a1 = (n1 <<< 1) - c1;
		base0 = (n0 + s64_t'(64'(h1a_q)) + s64_t'(64'(h2a_q))) <<< ACC_FRAC_BITS;
		base1 = (n1 + s64_t'(64'(h1b_q)) + s64_t'(64'(h2b_q))) <<< ACC_FRAC_BITS;
		sg = (n0 - s64_t'(64'(h1a_q)) - s64_t'(64'(h2a_q)))
			+ (n1 - s64_t'(64'(h1b_q)) - s64_t'(64'(h2b_q)));
		degenerate = (n0_q == '0) || (n1_q == '0) || (nt <= 64'sd2);
		ncm1 = nc_q - ONE;
		ne_x = 64'sd16777216 - s64_t'({{32{fst_q[31]}}, fst_q});
		fst2 = s64_t'({{31{fst_q[31]}}, fst_q, 1'b0});
		fx_shift = mul_rsp.prod >> ACC_FRAC_BITS;
		fx_mag = (|fx_shift[127:63]) ? u64_t'(S64_MAX) : fx_shift[63:0];
		quo_sat = clamp_mag(div_rsp.quo, div_rsp.ovf);
		unit_done = mul_rsp.done | div_rsp.done;
	end

	// Operands for the serial units; they are taken only on the start cycle.
	always_comb begin
		mul_req = '0;
		div_req = '0;
		case (state_q)
			ST_MA0: begin
				mul_req = '{start: !launched_q, a: mag(a0), b: mag(a0), len: LEN_SMALL};
			end
			ST_MC0: begin
				mul_req = '{start: !launched_q, a: u64_t'(c0), b: u64_t'(c0), len: LEN_SMALL};
			end
			ST_MA1: begin
				mul_req = '{start: !launched_q, a: mag(a1), b: mag(a1), len: LEN_SMALL};
			end
			ST_MC1: begin
				mul_req = '{start: !launched_q, a: u64_t'(c1), b: u64_t'(c1), len: LEN_SMALL};
			end
			ST_DT0: begin
				div_req = '{start: !launched_q, num: {64'd0, sq_q}, msb: MSB_64, sh: SH_F,
					den: u64_t'(n0 <<< 1)};
			end
			ST_DT1: begin
				div_req = '{start: !launched_q, num: {64'd0, sq_q}, msb: MSB_64, sh: SH_F,
					den: u64_t'(n1 <<< 1)};
			end
			ST_DMSI: begin
				div_req = '{start: !launched_q, num: {64'd0, mag(ssi_q)}, msb: MSB_64,
					sh: SH_NONE, den: u64_t'(nt - 64'sd2)};
			end
			ST_DMSG: begin
				div_req = '{start: !launched_q, num: {64'd0, mag(sg)}, msb: MSB_64, sh: SH_F,
					den: u64_t'(nt)};
			end
			ST_MD1: begin
				mul_req = '{start: !launched_q, a: u64_t'(c0), b: u64_t'(n1), len: LEN_CNT};
			end
			ST_MD2: begin
				mul_req = '{start: !launched_q, a: u64_t'(c1), b: u64_t'(n0), len: LEN_CNT};
			end
			ST_MNN: begin
				mul_req = '{start: !launched_q, a: u64_t'(n0), b: u64_t'(n1), len: LEN_CNT};
			end
			ST_MDD: begin
				mul_req = '{start: !launched_q, a: mag(d_q), b: mag(d_q), len: LEN_D};
			end
			ST_DMSP1: begin
				div_req = '{start: !launched_q, num: mul_rsp.prod, msb: MSB_128, sh: SH_F,
					den: u64_t'(nn_q)};
			end
			ST_DMSP2: begin
				div_req = '{start: !launched_q, num: {64'd0, p_q}, msb: MSB_64, sh: SH_NONE,
					den: u64_t'(nt)};
			end
			ST_DNC: begin
				div_req = '{start: !launched_q, num: {64'd0, nn_q <<< 1}, msb: MSB_64,
					sh: SH_F, den: u64_t'(nt)};
			end
			ST_MFX1: begin
				mul_req = '{start: !launched_q, a: mag(ncm1), b: mag(msi_q), len: LEN_FULL};
			end
			ST_MFX2: begin
				mul_req = '{start: !launched_q, a: u64_t'(nc_q), b: mag(msg_q), len: LEN_FULL};
			end
			ST_DFST: begin
				div_req = '{start: !launched_q && sfd_q != '0, num: {64'd0, mag(sfn_q)},
					msb: MSB_64, sh: OUT_FRAC, den: mag(sfd_q)};
			end
			ST_DFIS: begin
				div_req = '{start: !launched_q && sid_q != '0, num: {64'd0, mag(sin_q)},
					msb: MSB_64, sh: OUT_FRAC, den: mag(sid_q)};
			end
			ST_MNE: begin
				mul_req = '{start: !launched_q && !fst_bad_q, a: mag(ne_x),
					b: {48'd0, tau_q}, len: LEN_TAU};
			end
			ST_DNE: begin
				div_req = '{start: !launched_q, num: {64'd0, mag(tmp_q)}, msb: MSB_64,
					sh: SH_NONE, den: mag(fst2)};
			end
			default: ;
		endcase
	end

	// Sequencer: launch a unit, wait for it, write the result back and move on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			launched_q <= 1'b0;
			out_valid_q <= 1'b0;
			tau_q <= 16'd1;
			sfn_q <= '0;
			sfd_q <= '0;
			sin_q <= '0;
			sid_q <= '0;
			deg_q <= 1'b0;
		end else begin
			if (cfg_we) tau_q <= cfg_wdata;
			// A finished transfer empties the result register unless a new result loads it.
			if (out_valid_q && !out_stall && state_q != ST_DONE) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					launched_q <= 1'b0;
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (passes_q && !degenerate) begin
						state_q <= ST_MA0;
					end else begin
						if (passes_q) deg_q <= 1'b1;
						state_q <= last_q ? ST_DFST : ST_IDLE;
					end
				end
				ST_ACC1: begin
					sfn_q <= sat_add(sfn_q, sat_sub(msp_q, msi_q));
					sin_q <= sat_add(sin_q, sat_sub(msi_q, msg_q));
					state_q <= ST_ACC2;
				end
				ST_ACC2: begin
					sfd_q <= sat_add(sfd_q, sat_add(tmp_q, fx2_q));
					sid_q <= sat_add(sid_q, sat_add(msi_q, msg_q));
					state_q <= last_q ? ST_DFST : ST_IDLE;
				end
				ST_DFST: begin
					if (sfd_q == '0) state_q <= ST_DFIS;
					else if (unit_done) begin
						launched_q <= 1'b0;
						state_q <= ST_DFIS;
					end else launched_q <= 1'b1;
				end
				ST_DFIS: begin
					if (sid_q == '0) state_q <= ST_MNE;
					else if (unit_done) begin
						launched_q <= 1'b0;
						state_q <= ST_MNE;
					end else launched_q <= 1'b1;
				end
				ST_MNE: begin
					if (fst_bad_q) state_q <= ST_DONE;
					else if (unit_done) begin
						launched_q <= 1'b0;
						state_q <= ST_DNE;
					end else launched_q <= 1'b1;
				end
				ST_DONE: begin
					// The result register takes the transfer once the last one is gone.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						sfn_q <= '0;
						sfd_q <= '0;
						sin_q <= '0;
						sid_q <= '0;
						deg_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					if (unit_done) begin
						launched_q <= 1'b0;
						case (state_q)
							ST_MA0:   state_q <= ST_MC0;
							ST_MC0:   state_q <= ST_DT0;
							ST_DT0:   state_q <= ST_MA1;
							ST_MA1:   state_q <= ST_MC1;
							ST_MC1:   state_q <= ST_DT1;
							ST_DT1:   state_q <= ST_DMSI;
							ST_DMSI:  state_q <= ST_DMSG;
							ST_DMSG:  state_q <= ST_MD1;
							ST_MD1:   state_q <= ST_MD2;
							ST_MD2:   state_q <= ST_MNN;
							ST_MNN:   state_q <= ST_MDD;
							ST_MDD:   state_q <= ST_DMSP1;
							ST_DMSP1: state_q <= ST_DMSP2;
							ST_DMSP2: state_q <= ST_DNC;
							ST_DNC:   state_q <= ST_MFX1;
							ST_MFX1:  state_q <= ST_MFX2;
							ST_MFX2:  state_q <= ST_ACC1;
							default:  state_q <= ST_DONE;
						endcase
					end else begin
						launched_q <= 1'b1;
					end
				end
			endcase
		end
	end

	// Input capture and the working values of the current locus.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			h1a_q <= hom_one_first;
			hta_q <= het_first;
			h2a_q <= hom_two_first;
			n0_q <= size_first;
			h1b_q <= hom_one_second;
			htb_q <= het_second;
			h2b_q <= hom_two_second;
			n1_q <= size_second;
			passes_q <= locus_passes;
			last_q <= last_locus;
		end
		if (state_q == ST_DFST && sfd_q == '0) begin
			fst_q <= '0;
			fst_bad_q <= 1'b1;
		end
		if (state_q == ST_DFIS && sid_q == '0) begin
			fis_q <= '0;
			fis_bad_q <= 1'b1;
		end
		if (state_q == ST_MNE && fst_bad_q) ne_q <= '0;
		if (state_q == ST_ACC1) tmp_q <= sat_add(msp_q, fx1_q);
		if (unit_done) begin
			case (state_q)
				ST_MA0, ST_MA1: sq_q <= s64_t'(mul_rsp.prod[63:0]);
				ST_MC0, ST_MC1: sq_q <= sq_q + s64_t'(mul_rsp.prod[63:0]);
				ST_DT0:   ssi_q <= sat_sub(base0, s64_t'(quo_sat));
				ST_DT1:   ssi_q <= sat_add(ssi_q, sat_sub(base1, s64_t'(quo_sat)));
				ST_DMSI:  msi_q <= apply_sign(div_rsp.quo, ssi_q[63]);
				ST_DMSG:  msg_q <= apply_sign(div_rsp.quo, sg[63]);
				ST_MD1:   p_q <= s64_t'(mul_rsp.prod[63:0]);
				ST_MD2:   d_q <= p_q - s64_t'(mul_rsp.prod[63:0]);
				ST_MNN:   nn_q <= s64_t'(mul_rsp.prod[63:0]);
				ST_DMSP1: p_q <= s64_t'(quo_sat);
				ST_DMSP2: msp_q <= s64_t'(div_rsp.quo);
				ST_DNC:   nc_q <= s64_t'(quo_sat);
				ST_MFX1:  fx1_q <= apply_sign(fx_mag, ncm1[63] ^ msi_q[63]);
				ST_MFX2:  fx2_q <= apply_sign(fx_mag, msg_q[63]);
				ST_DFST: begin
					fst_q <= clamp32(apply_sign(quo_sat, sfn_q[63] ^ sfd_q[63]));
					fst_bad_q <= (clamp32(apply_sign(quo_sat, sfn_q[63] ^ sfd_q[63])) == '0);
				end
				ST_DFIS: begin
					fis_q <= clamp32(apply_sign(quo_sat, sin_q[63] ^ sid_q[63]));
					fis_bad_q <= 1'b0;
				end
				ST_MNE:   tmp_q <= apply_sign(mul_rsp.prod[63:0], ne_x[63]);
				ST_DNE:   ne_q <= clamp32(apply_sign(div_rsp.quo, tmp_q[63] ^ fst_q[31]));
				default: ;
			endcase
		end
		// Result register, loaded on the way back to idle.
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			fst_out_q <= fst_q;
			fis_out_q <= fis_q;
			ne_out_q <= ne_q;
			fst_inv_q <= fst_bad_q;
			fis_inv_q <= fis_bad_q;
			skip_q <= deg_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign fst_estimate = fst_out_q;
	assign fis_estimate = fis_out_q;
	assign effective_size = ne_out_q;
	assign fst_invalid = fst_inv_q;
	assign fis_invalid = fis_inv_q;
	assign skipped_seen = skip_q;

endmodule

>>> tb/tb_multilocus_fst_fis_accumulator.sv
module tb_multilocus_fst_fis_accumulator;

	typedef struct {
		logic [15:0] h1a, hta, h2a, n0, h1b, htb, h2b, n1;
		logic        pass, last;
	} locus_t;

	typedef struct {
		logic signed [31:0] fst, fis, ne;
		logic               fbad, ibad, skip;
	} estimate_t;

	localparam longint POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint NEG_MIN = 64'sh8000_0000_0000_0000;
	localparam int FRAC = 24;
	localparam longint CYCLE_LIMIT = 6000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] hom_one_first = '0, het_first = '0, hom_two_first = '0, size_first = '0;
	logic [15:0] hom_one_second = '0, het_second = '0, hom_two_second = '0, size_second = '0;
	logic locus_passes = 1'b0, last_locus = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] fst_estimate, fis_estimate, effective_size;
	logic fst_invalid, fis_invalid, skipped_seen;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	multilocus_fst_fis_accumulator i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.hom_one_first(hom_one_first), .het_first(het_first),
		.hom_two_first(hom_two_first), .size_first(size_first),
		.hom_one_second(hom_one_second), .het_second(het_second),
		.hom_two_second(hom_two_second), .size_second(size_second),
		.locus_passes(locus_passes), .last_locus(last_locus),
		.out_valid(out_valid), .out_stall(out_stall),
		.fst_estimate(fst_estimate), .fis_estimate(fis_estimate),
		.effective_size(effective_size), .fst_invalid(fst_invalid),
		.fis_invalid(fis_invalid), .skipped_seen(skipped_seen),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	locus_t locus_q[$];
	estimate_t estimate_q[$];
	locus_t cur_locus;
	int mismatches = 0;
	int results_seen = 0;
	longint cycle_count = 0;
	bit steady = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	// Predictor state: the four running sums, the skip flag and tau.
	longint sum_fst_num = 0, sum_fst_den = 0, sum_fis_num = 0, sum_fis_den = 0;
	bit skip_flag = 1'b0;
	longint tau = 1;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned abs_u(longint x);
		return x < 0 ? 64'd0 - longint'(x) : x;
	endfunction

	function automatic longint signed_of(longint unsigned m, bit neg);
		if (m > POS_MAX) m = POS_MAX;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint add_sat(longint a, longint b);
		logic signed [64:0] r;
		r = a;
		r = r + b;
		if (r > POS_MAX) return POS_MAX;
		if (r < NEG_MIN) return NEG_MIN;
		return r[63:0];
	endfunction

	function automatic longint sub_sat(longint a, longint b);
		logic signed [64:0] r;
		r = a;
		r = r - b;
		if (r > POS_MAX) return POS_MAX;
		if (r < NEG_MIN) return NEG_MIN;
		return r[63:0];
	endfunction

	// (num << sh) / d, truncated; any overflow of the 64-bit quotient saturates.
	function automatic longint unsigned scaled_quotient(bit [127:0] num, int sh,
			longint unsigned d);
		bit [191:0] w;
		bit [127:0] q;
		if (d == 0) return POS_MAX;
		w = {64'b0, num} << sh;
		if (w[191:128] != 0) return POS_MAX;
		if (w[127:64] >= d) return POS_MAX;
		q = w[127:0] / {64'b0, d};
		return q > POS_MAX ? POS_MAX : q[63:0];
	endfunction

	function automatic longint fixed_product(longint a, longint b);
		bit [127:0] p;
		longint unsigned rl;
		p = {64'b0, abs_u(a)} * {64'b0, abs_u(b)};
		rl = (p[127:88] != 0) ? POS_MAX : p[87:24];
		return signed_of(rl, (a < 0) != (b < 0));
	endfunction

	function automatic longint sample_ssi(longint n, longint h1, longint het, longint h2,
			output longint c);
		longint a, t, base;
		longint unsigned s;
		c = 2 * h1 + het;
		a = 2 * n - c;
		s = longint'(a * a) + longint'(c * c);
		t = scaled_quotient({64'b0, s}, FRAC, 2 * n);
		base = (n + h1 + h2) << FRAC;
		return sub_sat(base, t);
	endfunction

	// Folds one passing locus into the running sums, or only sets the skip flag if degenerate.
	function automatic void fold_locus(locus_t l);
		longint n0, n1, nt, one, c0, c1, ssi, msi, msg, msp, nc, d;
		longint unsigned dm;
		n0 = l.n0;
		n1 = l.n1;
		nt = n0 + n1;
		one = longint'(1) << FRAC;
		if (n0 == 0 || n1 == 0 || nt <= 2) begin
			skip_flag = 1'b1;
			return;
		end
		ssi = add_sat(sample_ssi(n0, l.h1a, l.hta, l.h2a, c0),
			sample_ssi(n1, l.h1b, l.htb, l.h2b, c1));
		msi = ssi / (nt - 2);
		msg = ((n0 - longint'(l.h1a) - longint'(l.h2a))
			+ (n1 - longint'(l.h1b) - longint'(l.h2b))) * one / nt;
		d = c0 * n1 - c1 * n0;
		dm = abs_u(d);
		msp = longint'(scaled_quotient({64'b0, dm} * {64'b0, dm}, FRAC, n0 * n1)) / nt;
		nc = scaled_quotient({64'b0, 2 * n0 * n1}, FRAC, nt);
		sum_fst_num = add_sat(sum_fst_num, sub_sat(msp, msi));
		sum_fst_den = add_sat(sum_fst_den, add_sat(add_sat(msp,
			fixed_product(sub_sat(nc, one), msi)), fixed_product(nc, msg)));
		sum_fis_num = add_sat(sum_fis_num, sub_sat(msi, msg));
		sum_fis_den = add_sat(sum_fis_den, add_sat(msi, msg));
	endfunction

	function automatic longint to_32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint ratio_q24(longint num, longint den);
		return to_32(signed_of(scaled_quotient({64'b0, abs_u(num)}, FRAC, abs_u(den)),
			(num < 0) != (den < 0)));
	endfunction

	// Forms the estimates at the end of a run of loci and clears the sums.
	function automatic void close_run();
		estimate_t e;
		longint fst, fis, ne, num;
		bit fbad, ibad;
		fst = 0;
		fis = 0;
		ne = 0;
		fbad = (sum_fst_den == 0);
		if (!fbad) fst = ratio_q24(sum_fst_num, sum_fst_den);
		if (fst == 0) fbad = 1'b1;
		ibad = (sum_fis_den == 0);
		if (!ibad) fis = ratio_q24(sum_fis_num, sum_fis_den);
		if (!fbad) begin
			num = tau * ((longint'(1) << FRAC) - fst);
			ne = to_32(num / (2 * fst));
		end
		e.fst = fst[31:0];
		e.fis = fis[31:0];
		e.ne = ne[31:0];
		e.fbad = fbad;
		e.ibad = ibad;
		e.skip = skip_flag;
		estimate_q.push_back(e);
		sum_fst_num = 0;
		sum_fst_den = 0;
		sum_fis_num = 0;
		sum_fis_den = 0;
		skip_flag = 1'b0;
	endfunction

	function automatic void predict(locus_t l);
		if (l.pass) fold_locus(l);
		if (l.last) close_run();
	endfunction

	// Input driver: predicts each transfer, then offers the next pending locus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) predict(cur_locus);
			if (!in_valid || !in_stall) begin
				if (locus_q.size() > 0 && (steady || $urandom_range(99) >= 29)) begin
					cur_locus = locus_q.pop_front();
					hom_one_first <= cur_locus.h1a;
					het_first <= cur_locus.hta;
					hom_two_first <= cur_locus.h2a;
					size_first <= cur_locus.n0;
					hom_one_second <= cur_locus.h1b;
					het_second <= cur_locus.htb;
					hom_two_second <= cur_locus.h2b;
					size_second <= cur_locus.n1;
					locus_passes <= cur_locus.pass;
					last_locus <= cur_locus.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each transfer and drives the receiver stall.
	always @(posedge clk or negedge arst_n) begin
		estimate_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (estimate_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Unexpected result transfer");
				end else begin
					e = estimate_q.pop_front();
					if (e.fst !== fst_estimate || e.fis !== fis_estimate
							|| e.ne !== effective_size || e.fbad !== fst_invalid
							|| e.ibad !== fis_invalid || e.skip !== skipped_seen) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %0d %0d %0d %b%b%b, got %0d %0d %0d %b%b%b",
								e.fst, e.fis, e.ne, e.fbad, e.ibad, e.skip,
								fst_estimate, fis_estimate, effective_size,
								fst_invalid, fis_invalid, skipped_seen);
					end
				end
			end
			// One long hold-off lets the block fill up behind a waiting result.
			if (!hold_done && results_seen == 5) begin
				hold_done <= 1'b1;
				hold_left <= 6000;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < 29);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic locus_t make_locus(logic [15:0] h1a, hta, h2a, n0, h1b, htb, h2b, n1,
			logic pass, logic last);
		locus_t l;
		l.h1a = h1a; l.hta = hta; l.h2a = h2a; l.n0 = n0;
		l.h1b = h1b; l.htb = htb; l.h2b = h2b; l.n1 = n1;
		l.pass = pass;
		l.last = last;
		return l;
	endfunction

	// A consistent locus: each sample's counts split its size.
	function automatic locus_t random_locus(logic last);
		locus_t l;
		int n, a, b;
		n = ($urandom_range(19) == 0) ? $urandom_range(65535, 1) : $urandom_range(300, 1);
		a = $urandom_range(n);
		b = $urandom_range(n - a);
		l.n0 = n; l.h1a = a; l.hta = b; l.h2a = n - a - b;
		n = ($urandom_range(19) == 0) ? $urandom_range(65535, 1) : $urandom_range(300, 1);
		a = $urandom_range(n);
		b = $urandom_range(n - a);
		l.n1 = n; l.h1b = a; l.htb = b; l.h2b = n - a - b;
		l.pass = $urandom_range(99) < 85;
		l.last = last;
		return l;
	endfunction

	function automatic locus_t noise_locus();
		return make_locus($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom_range(1), $urandom_range(3) == 0);
	endfunction

	task automatic write_tau(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		tau = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (locus_q.size() > 0 || in_valid || estimate_q.size() > 0) @(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		int k, len;
		k = 0;
		while (k < count) begin
			len = $urandom_range(6, 1);
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(9) == 0) locus_q.push_back(noise_locus());
				else locus_q.push_back(random_locus(j == len - 1));
				k++;
			end
		end
		locus_q.push_back(random_locus(1'b1));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed loci at reset tau: degenerate, failing, extremes and empty runs.
		locus_q.push_back(make_locus(0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
		locus_q.push_back(make_locus(1, 0, 0, 1, 0, 0, 1, 1, 1, 0));
		locus_q.push_back(make_locus(5, 3, 2, 10, 1, 4, 5, 10, 0, 1));
		locus_q.push_back(make_locus(2, 3, 5, 10, 0, 0, 0, 0, 1, 0));
		locus_q.push_back(make_locus(10, 5, 5, 20, 2, 8, 10, 20, 1, 1));
		locus_q.push_back(make_locus('1, '1, '1, '1, '1, '1, '1, '1, 1, 1));
		locus_q.push_back(make_locus('1, 0, 0, '1, 0, 0, '1, '1, 1, 1));
		locus_q.push_back(make_locus(0, '1, 0, '1, 0, '1, 0, '1, 1, 0));
		locus_q.push_back(make_locus(3, 4, 3, 10, 3, 4, 3, 10, 1, 1));
		locus_q.push_back(make_locus(0, 0, 0, 1, 0, 0, 0, 2, 1, 1));
		locus_q.push_back(make_locus(7, 0, 0, 3, 0, 9, 0, 2, 1, 1));
		locus_q.push_back(make_locus(40, 20, 40, 100, 60, 30, 10, 100, 1, 0));
		locus_q.push_back(make_locus(1, 1, 1, 3, 0, 0, 0, 5, 1, 1));
		locus_q.push_back(make_locus(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		random_phase(160);
		drain();

		write_tau(16'hFFFF);
		locus_q.push_back(make_locus(40, 20, 40, 100, 60, 30, 10, 100, 1, 1));
		random_phase(160);
		drain();

		// A stretch with no idling on either side.
		steady = 1'b1;
		write_tau(16'd1);
		random_phase(160);
		drain();
		steady = 1'b0;

		write_tau($urandom_range(65535, 1));
		random_phase(170);
		drain();

		write_tau(16'd37);
		random_phase(170);
		drain();

		if (mismatches == 0 && estimate_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
